// ===== rtl/tti_pkg.sv =====
// shared types, constants and the adc lookup table of the thermistor interpolator
`timescale 1ns / 1ps
package tti_pkg;

   localparam int ROM_SIZE    = 41;
   localparam int ROM_IDX_W   = 6;
   localparam int ADC_W       = 12;
   localparam int START_W     = 12;
   localparam int STEP_W      = 7;
   localparam int VAL_W       = 14;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 14;
   // step * (adc - entry) + span / 2
   localparam int NUM_W       = STEP_W + ADC_W + 1;
   localparam int QUOT_W      = STEP_W + 1;
   localparam int CNT_W       = $clog2(NUM_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_START = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_OVER  = CSR_IDX_W'(3);

   localparam logic signed [START_W-1:0] START_RESET = START_W'(200);
   localparam logic [STEP_W-1:0]         STEP_RESET  = STEP_W'(20);
   localparam logic signed [VAL_W-1:0]   UNDER_RESET = VAL_W'(200);
   localparam logic signed [VAL_W-1:0]   OVER_RESET  = VAL_W'(1000);

   localparam logic signed [15:0] VAL_MAX = 16'sd8191;
   localparam logic signed [15:0] VAL_MIN = -16'sd8192;

   // adc codes, descending with temperature
   localparam logic [ADC_W-1:0] ADC_ROM [ROM_SIZE] = '{
      12'd2275, 12'd2183, 12'd2093, 12'd2003, 12'd1915, 12'd1828, 12'd1742, 12'd1659,
      12'd1578, 12'd1499, 12'd1424, 12'd1350, 12'd1280, 12'd1212, 12'd1147, 12'd1085,
      12'd1026, 12'd969,  12'd915,  12'd864,  12'd816,  12'd770,  12'd727,  12'd686,
      12'd647,  12'd611,  12'd576,  12'd544,  12'd513,  12'd485,  12'd458,  12'd432,
      12'd408,  12'd385,  12'd364,  12'd344,  12'd325,  12'd308,  12'd291,  12'd276,
      12'd261
   };

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [15:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > VAL_MAX) begin
         r = VAL_MAX[VAL_W-1:0];
      end else if (v < VAL_MIN) begin
         r = VAL_MIN[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/tti_ifs.sv =====
// handshake interfaces for the sample, result and register write channels
`timescale 1ns / 1ps
interface tti_req_if;
   logic                      valid;
   logic                      ready;
   logic [tti_pkg::ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
   modport monitor (input valid, input adc_sample, input ready);
endinterface

interface tti_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [tti_pkg::VAL_W-1:0] temperature_tenths;
   modport source (output valid, output temperature_tenths, input ready);
   modport sink (input valid, input temperature_tenths, output ready);
   modport monitor (input valid, input temperature_tenths, input ready);
endinterface

interface tti_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tti_pkg::CSR_IDX_W-1:0]  index;
   logic [tti_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
   modport monitor (input valid, input index, input wdata, input ready);
endinterface

// ===== rtl/tti_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tti_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tti_pkg::NUM_W-1:0]     num,
   input  logic [tti_pkg::ADC_W-1:0]     den,
   output tti_pkg::div_status_type       status,
   output logic [tti_pkg::QUOT_W-1:0]    quot
);
   import tti_pkg::*;

   logic [ADC_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [ADC_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ADC_W:0]   shifted;
   logic [ADC_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, q_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = trial[ADC_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[ADC_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   // quotient never exceeds the step, so the low bits hold it
   assign quot = q_ff[QUOT_W-1:0];

endmodule

// ===== rtl/thermistor_table_interpolator_top.sv =====
// thermistor adc to temperature: table search, then interpolation with a serial divider
// one item at a time; ready only while idle
// readings outside the table go from the range check straight to the output stage,
// a reading on an entry skips the divider, and any other reading is interpolated
// by the divider (one numerator bit per cycle, 20 bits)
// synchronous active-high reset returns the registers to their defaults and clears the result valid
`timescale 1ns / 1ps
module thermistor_table_interpolator_top #(
   parameter int TABLE_ENTRIES = 41
) (
   input  logic      clock,
   input  logic      reset,
   tti_req_if.sink   req_port,
   tti_rsp_if.source rsp_port,
   tti_csr_if.sink   csr_port
);
   import tti_pkg::*;

   localparam int USED  = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
   localparam int IDX_W = $clog2(USED);
   localparam logic [IDX_W-1:0] LAST      = IDX_W'(USED - 1);
   localparam logic [ADC_W-1:0] FIRST_VAL = ADC_ROM[0];
   localparam logic [ADC_W-1:0] LAST_VAL  = ADC_ROM[USED - 1];

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_SEARCH = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_BASE   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [ADC_W-1:0]           adc_ff, adc_in;
   logic [IDX_W-1:0]           lo_ff, lo_in;
   logic [IDX_W-1:0]           hi_ff, hi_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [ADC_W-1:0]           diff_ff, diff_in;
   logic [ADC_W-1:0]           span_ff, span_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic signed [VAL_W-1:0]    res_ff, res_in;
   logic signed [START_W-1:0]  start_ff;
   logic [STEP_W-1:0]          step_ff;
   logic signed [VAL_W-1:0]    under_ff;
   logic signed [VAL_W-1:0]    over_ff;
   logic                       rsp_valid_ff;
   logic signed [VAL_W-1:0]    rsp_data_ff;

   logic [IDX_W:0]             mid_sum;
   logic [IDX_W-1:0]           mid;
   logic [IDX_W-1:0]           gap;
   logic [ADC_W-1:0]           rom_mid, rom_lo, rom_hi;
   logic [NUM_W-1:0]           num;
   logic                       div_start;
   div_status_type             div_status;
   logic [QUOT_W-1:0]          div_quot;
   logic signed [15:0]         ofs_s, base_s;
   logic                       out_free;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign gap     = hi_ff - lo_ff;
   assign rom_mid = ADC_ROM[ROM_IDX_W'(mid)];
   assign rom_lo  = ADC_ROM[ROM_IDX_W'(lo_ff)];
   assign rom_hi  = ADC_ROM[ROM_IDX_W'(hi_ff)];
   assign num     = NUM_W'(step_ff) * NUM_W'(diff_ff) + NUM_W'(span_ff >> 1);
   assign ofs_s   = signed'(16'(idx_ff) * 16'(step_ff));
   assign base_s  = 16'(start_ff) + ofs_s - signed'(16'(quot_ff));
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   tti_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num),
      .den    (span_ff),
      .status (div_status),
      .quot   (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      adc_in    = adc_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      diff_in   = diff_ff;
      span_in   = span_ff;
      quot_in   = quot_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               adc_in   = req_port.adc_sample;
               lo_in    = '0;
               hi_in    = LAST;
               quot_in  = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (adc_ff > FIRST_VAL) begin
               res_in   = under_ff;
               state_in = S_OUT;
            end else if (adc_ff < LAST_VAL) begin
               res_in   = over_ff;
               state_in = S_OUT;
            end else if (adc_ff == LAST_VAL) begin
               idx_in   = LAST;
               state_in = S_BASE;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (gap > IDX_W'(1)) begin
               if (adc_ff > rom_mid) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid;
               end
            end else if (adc_ff >= rom_lo) begin
               idx_in   = lo_ff;
               state_in = S_BASE;
            end else begin
               idx_in   = hi_ff;
               diff_in  = adc_ff - rom_hi;
               span_in  = rom_lo - rom_hi;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // zero span: no interpolation term
            if (span_ff == '0) begin
               state_in = S_BASE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               quot_in  = div_quot;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            res_in   = sat_val(base_s);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      adc_ff  <= adc_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      diff_ff <= diff_in;
      span_ff <= span_in;
      quot_ff <= quot_in;
      res_ff  <= res_in;
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= res_ff;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         step_ff  <= STEP_RESET;
         under_ff <= UNDER_RESET;
         over_ff  <= OVER_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_START: start_ff <= signed'(csr_port.wdata[START_W-1:0]);
            CSR_STEP:  step_ff  <= csr_port.wdata[STEP_W-1:0];
            CSR_UNDER: under_ff <= signed'(csr_port.wdata[VAL_W-1:0]);
            CSR_OVER:  over_ff  <= signed'(csr_port.wdata[VAL_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign req_port.ready              = (state_ff == S_IDLE);
   assign csr_port.ready              = 1'b1;
   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.temperature_tenths = rsp_data_ff;

endmodule

// ===== rtl/tti_checker.sv =====
// port-level checks of the thermistor interpolator, bound to the top level
`timescale 1ns / 1ps
module tti_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [tti_pkg::VAL_W-1:0] rsp_temperature_tenths,
   input logic                      csr_ready
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_temperature_tenths))
      else $error("result changed while stalled");

   // one item at a time: ready stays low after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("item accepted while busy");

   // a new result only comes out of a busy period
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without work");

   // register writes are never stalled
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind thermistor_table_interpolator_top tti_checker u_tti_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_port.valid),
   .req_ready              (req_port.ready),
   .rsp_valid              (rsp_port.valid),
   .rsp_ready              (rsp_port.ready),
   .rsp_temperature_tenths (rsp_port.temperature_tenths),
   .csr_ready              (csr_port.ready)
);

// ===== tb/thermistor_table_interpolator_top_tb.sv =====
// testbench for the thermistor table interpolator: random handshakes, register sweeps, result checks
`timescale 1ns / 1ps
module thermistor_table_interpolator_top_tb;
   import tti_pkg::*;

   localparam int TABLE_ENTRIES = 41;
   localparam int USED_ENTRIES  = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS   = 75;
   localparam int ADC_MAX       = (1 << ADC_W) - 1;

   typedef enum {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM
   } ready_mode_type;

   // expected temperatures, worked out from the register copy and the adc table
   class temperature_checker_type;
      logic signed [START_W-1:0] start_tenths;
      logic [STEP_W-1:0]         step_tenths;
      logic signed [VAL_W-1:0]   under_val;
      logic signed [VAL_W-1:0]   over_val;
      logic signed [VAL_W-1:0]   expected_temps[$];
      int                        mismatches;

      function new();
         start_tenths = START_RESET;
         step_tenths  = STEP_RESET;
         under_val    = UNDER_RESET;
         over_val     = OVER_RESET;
         mismatches   = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_START: start_tenths = data[START_W-1:0];
            CSR_STEP:  step_tenths  = data[STEP_W-1:0];
            CSR_UNDER: under_val    = data[VAL_W-1:0];
            CSR_OVER:  over_val     = data[VAL_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [VAL_W-1:0] predict_temperature(input logic [ADC_W-1:0] adc);
         int a, lo, hi, mid, base, step_i, res, span, num;
         a      = adc;
         lo     = 0;
         hi     = USED_ENTRIES - 1;
         base   = start_tenths;
         step_i = step_tenths;
         if (a > ADC_ROM[0]) begin
            res = under_val;
         end else if (a < ADC_ROM[hi]) begin
            res = over_val;
         end else if (a == ADC_ROM[hi]) begin
            res = base + hi * step_i;
         end else begin
            while (hi - lo > 1) begin
               mid = (lo + hi) / 2;
               if (a > ADC_ROM[mid]) begin
                  hi = mid;
               end else begin
                  lo = mid;
               end
            end
            if (a >= ADC_ROM[lo]) begin
               res = base + lo * step_i;
            end else begin
               span = int'(ADC_ROM[lo]) - int'(ADC_ROM[hi]);
               res  = base + hi * step_i;
               // round half up, counted back from the hotter entry
               if (span != 0) begin
                  num = step_i * (a - int'(ADC_ROM[hi])) + span / 2;
                  res = res - num / span;
               end
            end
         end
         if (res > VAL_MAX) begin
            res = VAL_MAX;
         end else if (res < VAL_MIN) begin
            res = VAL_MIN;
         end
         return res[VAL_W-1:0];
      endfunction

      function void note_sample(input logic [ADC_W-1:0] adc);
         expected_temps.push_back(predict_temperature(adc));
      endfunction

      function void check_result(input logic signed [VAL_W-1:0] actual);
         logic signed [VAL_W-1:0] want;
         if (expected_temps.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0d", $time, actual);
            mismatches++;
         end else begin
            want = expected_temps.pop_front();
            if (actual !== want) begin
               $display("%0t: temperature mismatch, expected %0d actual %0d",
                        $time, want, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_temps.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   burst_left;

   tti_req_if req_if();
   tti_rsp_if rsp_if();
   tti_csr_if csr_if();

   temperature_checker_type temps = new();

   thermistor_table_interpolator_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if.sink),
      .rsp_port(rsp_if.source),
      .csr_port(csr_if.sink)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL thermistor_table_interpolator_top");
      $finish;
   end

   // result side: checks every accepted item, stalls on its own changing pattern
   initial begin
      ready_mode_type mode;
      int             mode_left;
      mode      = READY_ALWAYS;
      mode_left = 200;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            temps.check_result(rsp_if.temperature_tenths);
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         case (mode)
            READY_ALWAYS: rsp_if.ready <= 1'b1;
            READY_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default:      rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_sample(input logic [ADC_W-1:0] adc);
      req_if.valid      <= 1'b1;
      req_if.adc_sample <= adc;
      do @(posedge clock); while (!req_if.ready);
      temps.note_sample(adc);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // hold off the sender until every result is back, then let the block go quiet
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (temps.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_if.ready);
      temps.write_register(idx, data[CSR_DATA_W-1:0]);
   endtask

   task automatic load_settings(input int start, input int step, input int under,
                                input int over);
      logic [CSR_IDX_W-1:0] spare_idx;
      // an index past the last register must be ignored
      spare_idx = CSR_OVER + CSR_IDX_W'($urandom_range(1, 4));
      write_csr(CSR_START, start);
      write_csr(CSR_STEP, step);
      write_csr(spare_idx, $urandom);
      write_csr(CSR_UNDER, under);
      write_csr(CSR_OVER, over);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ADC_W-1:0] random_sample();
      int pick;
      int near;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return ADC_W'($urandom_range(ADC_ROM[USED_ENTRIES-1], ADC_ROM[0]));
      end else if (pick < 82) begin
         // on an entry or one code away from it
         near = int'(ADC_ROM[$urandom_range(0, USED_ENTRIES - 1)]) + $urandom_range(0, 2) - 1;
         return ADC_W'(near);
      end
      return ADC_W'($urandom_range(0, ADC_MAX));
   endfunction

   task automatic run_random(input int count);
      repeat (count) begin
         send_sample(random_sample());
         if ($urandom_range(0, 149) == 0) begin
            settle_block();
         end
      end
   endtask

   initial begin
      logic [ADC_W-1:0] directed[24] = '{
         12'd0, 12'd4095, 12'd2276, 12'd2275, 12'd2274, 12'd2229, 12'd2230, 12'd2228,
         12'd2183, 12'd1999, 12'd1026, 12'd1000, 12'd262, 12'd261, 12'd260, 12'd276,
         12'd268, 12'd269, 12'h555, 12'hAAA, 12'h800, 12'h7FF, 12'd1578, 12'd300
      };
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.adc_sample <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_START;
      csr_if.wdata      <= '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults first
      foreach (directed[i]) begin
         send_sample(directed[i]);
      end
      run_random(PHASE_ITEMS);
      settle_block();

      load_settings(-1000, 1, -1000, 6000);
      run_random(PHASE_ITEMS);
      settle_block();

      load_settings(2000, 100, 6000, -1000);
      run_random(PHASE_ITEMS);
      settle_block();

      // full field extremes, then a zero step
      load_settings(-2048, 127, -8192, 8191);
      run_random(PHASE_ITEMS);
      settle_block();

      load_settings(2047, 0, 8191, -8192);
      run_random(PHASE_ITEMS);
      settle_block();

      repeat (4) begin
         load_settings(int'($urandom_range(0, 3000)) - 1000, $urandom_range(1, 100),
                       int'($urandom_range(0, 7000)) - 1000,
                       int'($urandom_range(0, 7000)) - 1000);
         run_random(PHASE_ITEMS);
         settle_block();
      end

      if (temps.mismatches == 0 && temps.pending() == 0) begin
         $display("PASS thermistor_table_interpolator_top");
      end else begin
         $display("FAIL thermistor_table_interpolator_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tti_pkg.sv
rtl/tti_ifs.sv
rtl/tti_div.sv
rtl/thermistor_table_interpolator_top.sv
rtl/tti_checker.sv
tb/thermistor_table_interpolator_top_tb.sv
